// ----- sv/nfie_pkg.sv -----
`default_nettype none
package nfie_pkg;

   localparam int ByteWidth = 8;
   localparam int ErrWidth = 2;
   localparam int PosWidth = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [ByteWidth-1:0] MaxPayload = 8'd247;
   localparam logic [ByteWidth-1:0] IdentReset = 8'hD4;
   localparam logic [ByteWidth-1:0] ByteZero = 8'h00;
   localparam logic [ByteWidth-1:0] ByteOnes = 8'hFF;

   localparam logic OpStart = 1'b0;
   localparam logic OpData = 1'b1;

   localparam logic [ErrWidth-1:0] ErrNone = 2'd0;
   localparam logic [ErrWidth-1:0] ErrTooLong = 2'd1;
   localparam logic [ErrWidth-1:0] ErrNoFrame = 2'd2;

   // byte positions of a frame on the wire
   localparam logic [PosWidth-1:0] PosPreamble = 3'd0;
   localparam logic [PosWidth-1:0] PosStart0 = 3'd1;
   localparam logic [PosWidth-1:0] PosStart1 = 3'd2;
   localparam logic [PosWidth-1:0] PosLen = 3'd3;
   localparam logic [PosWidth-1:0] PosLcs = 3'd4;
   localparam logic [PosWidth-1:0] PosMid = 3'd5;
   localparam logic [PosWidth-1:0] PosDcs = 3'd6;
   localparam logic [PosWidth-1:0] PosPost = 3'd7;

   // one queued command: a run of frame positions to serialize
   typedef struct packed {
      logic [PosWidth-1:0] start_pos;
      logic [PosWidth-1:0] stop_pos;
      logic [ByteWidth-1:0] len_field;
      logic [ByteWidth-1:0] mid_byte;
      logic [ByteWidth-1:0] dcs;
      logic [ErrWidth-1:0] error_code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

// ----- sv/nfie_req_if.sv -----
`default_nettype none
interface nfie_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic [nfie_pkg::ByteWidth-1:0] payload_length;
   logic [nfie_pkg::ByteWidth-1:0] data_byte;

   modport source (output valid, output opcode, output payload_length, output data_byte,
                   input ready);
   modport sink (input valid, input opcode, input payload_length, input data_byte,
                 output ready);
endinterface
`default_nettype wire

// ----- sv/nfie_rsp_if.sv -----
`default_nettype none
interface nfie_rsp_if;
   logic valid;
   logic ready;
   logic [nfie_pkg::ByteWidth-1:0] frame_byte;
   logic last_of_run;
   logic frame_done;
   logic [nfie_pkg::ErrWidth-1:0] error_code;

   modport source (output valid, output frame_byte, output last_of_run,
                   output frame_done, output error_code, input ready);
   modport sink (input valid, input frame_byte, input last_of_run,
                 input frame_done, input error_code, output ready);
endinterface
`default_nettype wire

// ----- sv/nfie_front.sv -----
`default_nettype none
module nfie_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [nfie_pkg::ByteWidth-1:0]  csr_wr_data,
   nfie_req_if.sink                             req_bus,
   input  wire nfie_pkg::q_status_type          q_status,
   output logic                                 push,
   output nfie_pkg::cmd_type                    cmd
);
   import nfie_pkg::*;

   logic [ByteWidth-1:0] ident_ff;
   logic frame_open_ff, frame_open_in;
   logic [ByteWidth-1:0] remaining_ff, remaining_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [ByteWidth-1:0] len_field;
   logic [ByteWidth-1:0] sum_next;
   logic [ByteWidth-1:0] remaining_next;

   assign req_bus.ready = !q_status.full;
   assign push = req_bus.valid && !q_status.full;

   assign len_field = req_bus.payload_length + 8'd1;
   assign sum_next = sum_ff + req_bus.data_byte;
   assign remaining_next = remaining_ff - 8'd1;

   always_comb begin
      frame_open_in = frame_open_ff;
      remaining_in = remaining_ff;
      sum_in = sum_ff;
      cmd.start_pos = PosMid;
      cmd.stop_pos = PosMid;
      cmd.len_field = len_field;
      cmd.mid_byte = ByteZero;
      cmd.dcs = ByteZero;
      cmd.error_code = ErrNone;
      if (req_bus.opcode == OpStart) begin
         frame_open_in = 1'b0;
         remaining_in = ByteZero;
         if (req_bus.payload_length > MaxPayload) begin
            cmd.error_code = ErrTooLong;
         end else begin
            sum_in = ident_ff;
            cmd.start_pos = PosPreamble;
            cmd.mid_byte = ident_ff;
            cmd.dcs = ByteZero - ident_ff;
            if (req_bus.payload_length == ByteZero) begin
               cmd.stop_pos = PosPost;
            end else begin
               frame_open_in = 1'b1;
               remaining_in = req_bus.payload_length;
            end
         end
      end else if (!frame_open_ff) begin
         cmd.error_code = ErrNoFrame;
      end else begin
         sum_in = sum_next;
         remaining_in = remaining_next;
         cmd.mid_byte = req_bus.data_byte;
         cmd.dcs = ByteZero - sum_next;
         if (remaining_next == ByteZero) begin
            cmd.stop_pos = PosPost;
            frame_open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= IdentReset;
         frame_open_ff <= 1'b0;
         remaining_ff <= ByteZero;
         sum_ff <= ByteZero;
      end else begin
         if (csr_wr_en) begin
            ident_ff <= csr_wr_data;
         end
         if (push) begin
            frame_open_ff <= frame_open_in;
            remaining_ff <= remaining_in;
            sum_ff <= sum_in;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/nfie_queue.sv -----
`default_nettype none
module nfie_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire nfie_pkg::cmd_type       push_cmd,
   input  wire logic                    pop,
   output nfie_pkg::cmd_type            head_cmd,
   output nfie_pkg::q_status_type       q_status
);
   import nfie_pkg::*;

   cmd_type store_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff;
   logic [QueuePtrWidth-1:0] rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_ff;
   logic do_push;
   logic do_pop;

   assign q_status.full = (count_ff == QueueCntWidth'(QueueDepth));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop = pop && !q_status.empty;
   assign head_cmd = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/nfie_back.sv -----
`default_nettype none
module nfie_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire nfie_pkg::cmd_type       head_cmd,
   input  wire nfie_pkg::q_status_type  q_status,
   output logic                         pop,
   nfie_rsp_if.source                   rsp_bus
);
   import nfie_pkg::*;

   logic busy_ff, busy_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [PosWidth-1:0] pos;
   logic emit;
   logic at_stop;
   logic [ByteWidth-1:0] byte_sel;
   logic rsp_valid_ff;
   logic [ByteWidth-1:0] frame_byte_ff;
   logic last_ff;
   logic done_ff;
   logic [ErrWidth-1:0] err_ff;

   // first byte of a command comes straight from the queue head
   assign pos = busy_ff ? pos_ff : head_cmd.start_pos;
   assign at_stop = (pos == head_cmd.stop_pos);
   assign emit = !q_status.empty && (!rsp_valid_ff || rsp_bus.ready);
   assign pop = emit && at_stop;

   always_comb begin
      case (pos)
         PosPreamble: byte_sel = ByteZero;
         PosStart0:   byte_sel = ByteZero;
         PosStart1:   byte_sel = ByteOnes;
         PosLen:      byte_sel = head_cmd.len_field;
         PosLcs:      byte_sel = ByteZero - head_cmd.len_field;
         PosMid:      byte_sel = head_cmd.mid_byte;
         PosDcs:      byte_sel = head_cmd.dcs;
         PosPost:     byte_sel = ByteZero;
         default:     byte_sel = ByteZero;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in = pos_ff;
      if (emit) begin
         busy_in = !at_stop;
         pos_in = pos + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= PosPreamble;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pos_ff <= pos_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         frame_byte_ff <= byte_sel;
         last_ff <= at_stop;
         done_ff <= (pos == PosPost);
         err_ff <= head_cmd.error_code;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.frame_byte = frame_byte_ff;
   assign rsp_bus.last_of_run = last_ff;
   assign rsp_bus.frame_done = done_ff;
   assign rsp_bus.error_code = err_ff;

endmodule
`default_nettype wire

// ----- sv/nfc_information_frame_encoder_unit.sv -----
// each item is registered in the command queue, then its results in the output register
// throughput: one result per cycle while a command is queued and each result is taken;
// a start item sends preamble up to identifier (up to postamble for an empty frame), a data
// item its byte (then data checksum and postamble if last), an error one byte; a 4-entry command
// queue sits between classifier and serializer, input is stalled only while that queue is full
// reset: synchronous, clears frame state and queue, identifier back to 0xD4
`default_nettype none
module nfc_information_frame_encoder_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [nfie_pkg::ByteWidth-1:0]  csr_wr_data,
   nfie_req_if.sink                             req_bus,
   nfie_rsp_if.source                           rsp_bus
);
   import nfie_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   q_status_type q_status;
   logic push;
   logic pop;

   nfie_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .q_status    (q_status),
      .push        (push),
      .cmd         (push_cmd)
   );

   nfie_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   nfie_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire
